// ----- rtl/escp_pkg.sv -----
// Package for the expert slot cache policy block.
// Shared types and size constants; no dependencies.
package escp_pkg;
  localparam int MaxSlots   = 32;
  localparam int BatchSize  = 8;
  localparam int NumExperts = 256;
  localparam int IdW        = 8;
  localparam int CfgW       = 6;
  localparam int FreqW      = 32;
  localparam int AgeW       = 64;
  localparam logic [CfgW-1:0] SlotsReset = 6'd16;
endpackage

// ----- rtl/escp_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module escp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/expert_slot_cache_policy_core.sv -----
// Expert slot cache policy: gathers a batch of expert ids, counts uses, then
// assigns a slot to every rank with LFU replacement and an oldest-age tie break.
// Depends on escp_pkg and escp_ram (use count table).
//
// After reset the block sweeps the use count table, one entry per cycle,
// before it takes items. Closing a batch, for each rank, counts its use (read,
// wait, write) and looks it up among the active slots; then, for each miss, it
// scans the active slots for a victim (an empty slot is taken at once, reserved
// slots are skipped, occupied ones need one use count memory read each); then
// results go out one per cycle while the receiver is ready.
module expert_slot_cache_policy_core #(
  parameter int MAX_SLOTS   = escp_pkg::MaxSlots,
  parameter int BATCH_SIZE  = escp_pkg::BatchSize,
  parameter int NUM_EXPERTS = escp_pkg::NumExperts
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // expert_id[7:0]
  input  logic                     s_tlast,   // batch_last
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [23:0]              m_tdata,   // rank_index[2:0], expert_out[10:3],
                                              // slot_index[15:11], was_miss[16]
  output logic                     m_tlast,   // last_result
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [escp_pkg::CfgW-1:0] cfg_data
);
  import escp_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int BW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int CW = $clog2(BATCH_SIZE + 1);
  localparam int EW = $clog2(NUM_EXPERTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_UC_RD, S_UC_WAIT, S_UC_WR, S_LOOK, S_VIC_INIT,
    S_VIC_RD, S_VIC_CMP, S_VIC_FILL, S_OUT
  } state_t;

  state_t state;
  logic [CfgW-1:0] slots_in_use;
  logic [MAX_SLOTS-1:0] slot_valid, reserved;
  logic [IdW-1:0] slot_expert [MAX_SLOTS];
  logic [AgeW-1:0] slot_age [MAX_SLOTS];
  logic [AgeW-1:0] age_clock;
  logic [IdW-1:0] batch_ids [BATCH_SIZE];
  logic [SW-1:0] sel [BATCH_SIZE];
  logic [BATCH_SIZE-1:0] miss;
  logic [CW-1:0] count;
  logic [BW-1:0] rank;
  logic [SW:0] scan;
  logic [EW-1:0] clr_addr;
  logic vfound, vempty;
  logic [SW-1:0] victim;
  logic [FreqW-1:0] vfreq;

  logic uc_we;
  logic [EW-1:0] uc_addr;
  logic [FreqW-1:0] uc_wdata, uc_rdata;

  escp_ram #(.Width(FreqW), .Depth(NUM_EXPERTS)) u_use_count (
    .clk(clk), .we(uc_we), .addr(uc_addr), .wdata(uc_wdata), .rdata(uc_rdata)
  );

  logic [NW-1:0] n_act;
  always_comb begin
    if (int'(slots_in_use) < BATCH_SIZE) begin
      n_act = NW'(BATCH_SIZE);
    end else if (int'(slots_in_use) > MAX_SLOTS) begin
      n_act = NW'(MAX_SLOTS);
    end else begin
      n_act = NW'(slots_in_use);
    end
  end

  logic [SW-1:0] si;
  logic [IdW-1:0] cur_id;
  logic [AgeW-1:0] age_inc;
  assign si = scan[SW-1:0];
  assign cur_id = batch_ids[rank];
  assign age_inc = age_clock + 1'b1;

  always_comb begin
    uc_we = 1'b0;
    uc_wdata = uc_rdata + 1'b1;
    uc_addr = EW'(cur_id);
    case (state)
      S_CLR: begin
        uc_we = 1'b1;
        uc_addr = clr_addr;
        uc_wdata = '0;
      end
      S_UC_WR: uc_we = 1'b1;
      S_VIC_RD: uc_addr = EW'(slot_expert[si]);
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      slots_in_use <= SlotsReset;
      slot_valid <= '0;
      reserved <= '0;
      age_clock <= '0;
      count <= '0;
      rank <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_age[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        slots_in_use <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (int'(clr_addr) == NUM_EXPERTS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            batch_ids[count[BW-1:0]] <= s_tdata;
            count <= count + 1'b1;
            if (s_tlast || int'(count) == BATCH_SIZE - 1) begin
              state <= S_UC_RD;
              rank <= '0;
              reserved <= '0;
            end
          end
        end
        S_UC_RD: state <= S_UC_WAIT;
        S_UC_WAIT: state <= S_UC_WR;
        S_UC_WR: begin
          miss[rank] <= 1'b1;
          sel[rank] <= '0;
          scan <= '0;
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (NW'(scan) >= n_act) begin
            if (int'(rank) + 1 == int'(count)) begin
              rank <= '0;
              state <= S_VIC_INIT;
            end else begin
              rank <= rank + 1'b1;
              state <= S_UC_RD;
            end
          end else if (slot_valid[si] && slot_expert[si] == cur_id) begin
            sel[rank] <= si;
            miss[rank] <= 1'b0;
            reserved[si] <= 1'b1;
            slot_age[si] <= age_inc;
            age_clock <= age_inc;
            scan <= (SW+1)'(n_act);
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_VIC_INIT: begin
          scan <= '0;
          vfound <= 1'b0;
          vempty <= 1'b0;
          victim <= '0;
          if (!miss[rank]) begin
            state <= S_VIC_FILL;
          end else begin
            state <= S_VIC_RD;
          end
        end
        S_VIC_RD: begin
          if (NW'(scan) >= n_act || vempty) begin
            state <= S_VIC_FILL;
          end else if (reserved[si]) begin
            scan <= scan + 1'b1;
          end else if (!slot_valid[si]) begin
            victim <= si;
            vfound <= 1'b1;
            vempty <= 1'b1;
            state <= S_VIC_FILL;
          end else begin
            state <= S_VIC_CMP;
          end
        end
        S_VIC_CMP: begin
          if (!vfound || uc_rdata < vfreq ||
              (uc_rdata == vfreq && slot_age[si] < slot_age[victim])) begin
            victim <= si;
            vfreq <= uc_rdata;
          end
          vfound <= 1'b1;
          scan <= scan + 1'b1;
          state <= S_VIC_RD;
        end
        S_VIC_FILL: begin
          if (miss[rank] && vfound) begin
            slot_valid[victim] <= 1'b1;
            slot_expert[victim] <= cur_id;
            slot_age[victim] <= age_inc;
            age_clock <= age_inc;
            reserved[victim] <= 1'b1;
            sel[rank] <= victim;
          end
          if (int'(rank) + 1 == int'(count)) begin
            rank <= '0;
            state <= S_OUT;
            m_tvalid <= 1'b1;
          end else begin
            rank <= rank + 1'b1;
            state <= S_VIC_INIT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (int'(rank) + 1 == int'(count)) begin
              m_tvalid <= 1'b0;
              count <= '0;
              state <= S_IDLE;
            end else begin
              rank <= rank + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [2:0] rank_o;
  logic [4:0] slot_o;
  assign rank_o = 3'(rank);
  assign slot_o = 5'(sel[rank]);
  assign m_tdata = {7'd0, miss[rank], slot_o, cur_id, rank_o};
  assign m_tlast = (int'(rank) + 1 == int'(count));

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("result valid outside output phase");
  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("input ready while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= BATCH_SIZE) else $error("batch count overflow");
`endif
endmodule
